// File: rtl/wmm_pkg.sv
`timescale 1ns / 1ps

package wmm_pkg;

   typedef enum logic [1:0] {
      OP_CLEAR   = 2'd0,
      OP_ADD     = 2'd1,
      OP_TEXT    = 2'd2,
      OP_RESTART = 2'd3
   } opcode_type;

   localparam int WORD_BITS     = 64;
   localparam int LEN_BITS      = 4;
   localparam int START_BITS    = 16;
   localparam int TDATA_BITS    = 80;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [CSR_ADDR_BITS-1:0] ADDR_WORD_LENGTH = 3'd0;

   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
   } eng_status_type;

   typedef struct packed {
      logic                  valid;
      logic [START_BITS-1:0] start;
   } eng_result_type;

endpackage

// File: rtl/wmm_dict.sv
`timescale 1ns / 1ps

module wmm_dict #(
   parameter int DICT_WORDS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               clear,
   input  logic                               add_valid,
   input  logic [wmm_pkg::WORD_BITS-1:0]      key,
   output logic [$clog2(DICT_WORDS+1)-1:0]    lookup_id,
   output logic [$clog2(DICT_WORDS+1)-1:0]    distinct_after,
   output logic [$clog2(DICT_WORDS+1)-1:0]    total,
   output logic                               pend,
   input  logic [$clog2(DICT_WORDS+1)-1:0]    rd_a_id,
   input  logic [$clog2(DICT_WORDS+1)-1:0]    rd_b_id,
   output logic [$clog2(DICT_WORDS+1)-1:0]    rd_a,
   output logic [$clog2(DICT_WORDS+1)-1:0]    rd_b
);

   localparam int ID_W  = $clog2(DICT_WORDS+1);
   localparam int IDX_W = (DICT_WORDS > 1) ? $clog2(DICT_WORDS) : 1;
   localparam logic [ID_W-1:0] NOT_WORD = ID_W'(DICT_WORDS);

   logic [wmm_pkg::WORD_BITS-1:0] words_ff [DICT_WORDS];
   logic [ID_W-1:0]               req_mem  [DICT_WORDS];
   logic [ID_W-1:0]               distinct_ff, distinct_in;
   logic [ID_W-1:0]               total_ff, total_in;
   logic                          pend_ff, pend_in;
   logic [IDX_W-1:0]              pend_idx_ff;
   logic [ID_W-1:0]               rd_a_raw_ff, rd_b_raw_ff;
   logic                          a_nw_ff, b_nw_ff;
   logic                          found;
   logic                          add_new, add_dup;
   logic [IDX_W-1:0]              a_addr;

   always_comb begin
      lookup_id = NOT_WORD;
      found     = 1'b0;
      for (int i = DICT_WORDS - 1; i >= 0; i--) begin
         if ((ID_W'(i) < distinct_ff) && (words_ff[i] == key)) begin
            lookup_id = ID_W'(i);
            found     = 1'b1;
         end
      end
   end

   assign add_new = add_valid && (total_ff < NOT_WORD) && !found;
   assign add_dup = add_valid && (total_ff < NOT_WORD) && found;
   assign distinct_after = add_new ? distinct_ff + 1'b1 : distinct_ff;
   assign a_addr = add_dup ? lookup_id[IDX_W-1:0] : rd_a_id[IDX_W-1:0];

   always_comb begin
      distinct_in = distinct_after;
      total_in    = (add_new || add_dup) ? total_ff + 1'b1 : total_ff;
      pend_in     = add_dup;
      if (clear) begin
         distinct_in = '0;
         total_in    = '0;
         pend_in     = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         distinct_ff <= '0;
         total_ff    <= '0;
         pend_ff     <= 1'b0;
      end else begin
         distinct_ff <= distinct_in;
         total_ff    <= total_in;
         pend_ff     <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (add_new) begin
         words_ff[distinct_ff[IDX_W-1:0]] <= key;
      end
   end

   // required counts: two read ports, one write port
   always_ff @(posedge clock) begin
      rd_a_raw_ff <= req_mem[a_addr];
      rd_b_raw_ff <= req_mem[rd_b_id[IDX_W-1:0]];
      a_nw_ff     <= (rd_a_id == NOT_WORD);
      b_nw_ff     <= (rd_b_id == NOT_WORD);
      pend_idx_ff <= lookup_id[IDX_W-1:0];
      if (add_new) begin
         req_mem[distinct_ff[IDX_W-1:0]] <= ID_W'(1);
      end else if (pend_ff) begin
         req_mem[pend_idx_ff] <= rd_a_raw_ff + 1'b1;
      end
   end

   assign rd_a  = a_nw_ff ? '0 : rd_a_raw_ff;
   assign rd_b  = b_nw_ff ? '0 : rd_b_raw_ff;
   assign total = total_ff;
   assign pend  = pend_ff;

endmodule

// File: rtl/wmm_engine.sv
`timescale 1ns / 1ps

module wmm_engine #(
   parameter int MAX_WORD_BYTES = 8,
   parameter int DICT_WORDS     = 16
) (
   input  logic                                              clock,
   input  logic                                              reset,
   input  logic                                              restart,
   input  logic [$clog2(DICT_WORDS+2)-1:0]                   restart_tally,
   input  logic                                              step_valid,
   input  logic [((MAX_WORD_BYTES > 1) ? $clog2(MAX_WORD_BYTES) : 1)-1:0] step_group,
   input  logic [$clog2(DICT_WORDS+1)-1:0]                   step_id,
   input  logic [wmm_pkg::START_BITS-1:0]                    step_start,
   input  logic [$clog2(DICT_WORDS+1)-1:0]                   total,
   output logic [$clog2(DICT_WORDS+1)-1:0]                   rq_a_id,
   output logic [$clog2(DICT_WORDS+1)-1:0]                   rq_b_id,
   input  logic [$clog2(DICT_WORDS+1)-1:0]                   rq_a,
   input  logic [$clog2(DICT_WORDS+1)-1:0]                   rq_b,
   output wmm_pkg::eng_status_type                           status,
   output wmm_pkg::eng_result_type                           result
);

   localparam int GRP_W   = (MAX_WORD_BYTES > 1) ? $clog2(MAX_WORD_BYTES) : 1;
   localparam int ID_W    = $clog2(DICT_WORDS+1);
   localparam int SLOT_W  = (DICT_WORDS > 1) ? $clog2(DICT_WORDS) : 1;
   localparam int TALLY_W = $clog2(DICT_WORDS+2);
   localparam int I_DEPTH = MAX_WORD_BYTES * DICT_WORDS;
   localparam int C_DEPTH = MAX_WORD_BYTES * (DICT_WORDS + 1);
   localparam int IADDR_W = (I_DEPTH > 1) ? $clog2(I_DEPTH) : 1;
   localparam int CADDR_W = $clog2(C_DEPTH);

   // per-group ring pointers
   logic [ID_W-1:0]   fill_ff  [MAX_WORD_BYTES];
   logic [SLOT_W-1:0] head_ff  [MAX_WORD_BYTES];
   logic [TALLY_W-1:0] tally_ff [MAX_WORD_BYTES];

   logic [ID_W-1:0]    ids_mem  [I_DEPTH];
   logic [ID_W-1:0]    cnt_mem  [C_DEPTH];
   logic [C_DEPTH-1:0] cvalid_ff;

   logic [ID_W-1:0]    s0_fill, fill_new;
   logic [SLOT_W-1:0]  s0_head, head_inc, s0_slot;
   logic [ID_W:0]      slot_sum;
   logic               s0_evict, s0_insert;
   logic [IADDR_W-1:0] ids_wr_addr, ids_rd_addr;
   logic [ID_W-1:0]    ids_rd_ff;

   logic               s1_valid_ff, s1_evict_ff, s1_insert_ff, s1_full_ff;
   logic [GRP_W-1:0]   s1_group_ff;
   logic [ID_W-1:0]    s1_id_ff;
   logic [wmm_pkg::START_BITS-1:0] s1_start_ff;
   logic [CADDR_W-1:0] ca_addr, cb_addr;

   logic               s2_valid_ff, s2_evict_ff, s2_insert_ff, s2_full_ff;
   logic [GRP_W-1:0]   s2_group_ff;
   logic [ID_W-1:0]    s2_id_ff, s2_old_ff;
   logic [wmm_pkg::START_BITS-1:0] s2_start_ff;
   logic [CADDR_W-1:0] s2_ca_ff, s2_cb_ff;
   logic [ID_W-1:0]    cnt_a_ff, cnt_b_ff;

   logic               s3_valid_ff;
   logic [CADDR_W-1:0] s3_addr_ff;
   logic [ID_W-1:0]    s3_data_ff;

   logic               lw_valid_ff;
   logic [CADDR_W-1:0] lw_addr_ff;
   logic [ID_W-1:0]    lw_data_ff;

   logic               wr_valid;
   logic [CADDR_W-1:0] wr_addr;
   logic [ID_W-1:0]    wr_data;

   logic [ID_W-1:0]    ca, cb, c_dn, cu0, c_up;
   logic [TALLY_W-1:0] t0, t1, t1b, t2a, t2;
   logic               same;

   // stage 0: ring bookkeeping, id write, oldest id read
   always_comb begin
      s0_fill   = fill_ff[step_group];
      s0_head   = head_ff[step_group];
      s0_evict  = (s0_fill >= total) && (s0_fill != '0);
      s0_insert = (total != '0);
      head_inc  = (s0_head == SLOT_W'(DICT_WORDS - 1)) ? '0 : s0_head + 1'b1;
      slot_sum  = (ID_W+1)'(s0_head) + (ID_W+1)'(s0_fill);
      s0_slot   = (slot_sum >= (ID_W+1)'(DICT_WORDS)) ?
                  SLOT_W'(slot_sum - (ID_W+1)'(DICT_WORDS)) : SLOT_W'(slot_sum);
      fill_new  = s0_fill - ID_W'(s0_evict) + ID_W'(s0_insert);
      ids_wr_addr = IADDR_W'(int'(step_group) * DICT_WORDS + int'(s0_slot));
      ids_rd_addr = IADDR_W'(int'(step_group) * DICT_WORDS + int'(s0_head));
   end

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         for (int g = 0; g < MAX_WORD_BYTES; g++) begin
            fill_ff[g] <= '0;
            head_ff[g] <= '0;
         end
      end else if (step_valid) begin
         fill_ff[step_group] <= fill_new;
         head_ff[step_group] <= s0_evict ? head_inc : s0_head;
      end
   end

   always_ff @(posedge clock) begin
      ids_rd_ff <= ids_mem[ids_rd_addr];
      if (step_valid && s0_insert) begin
         ids_mem[ids_wr_addr] <= step_id;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= step_valid;
      end
      s1_group_ff  <= step_group;
      s1_id_ff     <= step_id;
      s1_evict_ff  <= s0_evict;
      s1_insert_ff <= s0_insert;
      s1_full_ff   <= s0_insert && (fill_new == total);
      s1_start_ff  <= step_start;
   end

   // stage 1: count reads for the evicted and the inserted id
   assign ca_addr = CADDR_W'(int'(s1_group_ff) * (DICT_WORDS + 1) + int'(ids_rd_ff));
   assign cb_addr = CADDR_W'(int'(s1_group_ff) * (DICT_WORDS + 1) + int'(s1_id_ff));
   assign rq_a_id = ids_rd_ff;
   assign rq_b_id = s1_id_ff;

   always_ff @(posedge clock) begin
      cnt_a_ff <= cvalid_ff[ca_addr] ? cnt_mem[ca_addr] : '0;
      cnt_b_ff <= cvalid_ff[cb_addr] ? cnt_mem[cb_addr] : '0;
      if (wr_valid) begin
         cnt_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         cvalid_ff <= '0;
      end else if (wr_valid) begin
         cvalid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
      s2_group_ff  <= s1_group_ff;
      s2_id_ff     <= s1_id_ff;
      s2_old_ff    <= ids_rd_ff;
      s2_evict_ff  <= s1_evict_ff;
      s2_insert_ff <= s1_insert_ff;
      s2_full_ff   <= s1_full_ff;
      s2_start_ff  <= s1_start_ff;
      s2_ca_ff     <= ca_addr;
      s2_cb_ff     <= cb_addr;
   end

   // stage 2: adjust counts and tally; forward the write the read missed
   always_comb begin
      ca   = (lw_valid_ff && (lw_addr_ff == s2_ca_ff)) ? lw_data_ff : cnt_a_ff;
      cb   = (lw_valid_ff && (lw_addr_ff == s2_cb_ff)) ? lw_data_ff : cnt_b_ff;
      same = s2_evict_ff && (s2_old_ff == s2_id_ff);
      t0   = tally_ff[s2_group_ff];

      c_dn = (ca == '0) ? '0 : ca - 1'b1;
      t1   = t0 + TALLY_W'(ca == rq_a);
      t1b  = ((c_dn == rq_a) && (t1 != '0)) ? t1 - 1'b1 : t1;
      if (!s2_evict_ff) begin
         t1b = t0;
      end

      cu0  = same ? c_dn : cb;
      t2a  = t1b + TALLY_W'(cu0 == rq_b);
      c_up = cu0 + 1'b1;
      t2   = ((c_up == rq_b) && (t2a != '0)) ? t2a - 1'b1 : t2a;
      if (!s2_insert_ff) begin
         t2 = t1b;
      end

      wr_valid = 1'b0;
      wr_addr  = s2_ca_ff;
      wr_data  = c_dn;
      if (s2_valid_ff) begin
         if (s2_evict_ff) begin
            wr_valid = 1'b1;
            wr_data  = same ? c_up : c_dn;
         end else if (s2_insert_ff) begin
            wr_valid = 1'b1;
            wr_addr  = s2_cb_ff;
            wr_data  = c_up;
         end
      end else if (s3_valid_ff) begin
         wr_valid = 1'b1;
         wr_addr  = s3_addr_ff;
         wr_data  = s3_data_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
         lw_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s2_valid_ff && s2_evict_ff && s2_insert_ff && !same;
         lw_valid_ff <= wr_valid;
      end
      s3_addr_ff <= s2_cb_ff;
      s3_data_ff <= c_up;
      lw_addr_ff <= wr_addr;
      lw_data_ff <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int g = 0; g < MAX_WORD_BYTES; g++) begin
            tally_ff[g] <= '0;
         end
      end else if (restart) begin
         for (int g = 0; g < MAX_WORD_BYTES; g++) begin
            tally_ff[g] <= restart_tally;
         end
      end else if (s2_valid_ff) begin
         tally_ff[s2_group_ff] <= t2;
      end
   end

   assign result.valid = s2_valid_ff && s2_full_ff && (t2 == '0);
   assign result.start = s2_start_ff;
   assign status.s1    = s1_valid_ff;
   assign status.s2    = s2_valid_ff;
   assign status.s3    = s3_valid_ff;

endmodule

// File: rtl/word_multiset_window_matcher_core.sv
`timescale 1ns / 1ps

// Word multiset window matcher.
// req_* carries one transaction per item: opcode, dictionary word or text byte.
// Opcode clear empties the dictionary; add stores a word of word_length bytes;
// text pushes one byte; restart starts a new text. Add and clear also restart.
// rsp_* carries the start position of each window of concatenated words that
// is a permutation of the dictionary; at most one transaction per text byte.
// csr_* is an APB port holding word_length at address 0; a write to it clears all.
// A text byte that completes a word holds off the next item while its step is in
// stage 1, set by the read-modify-write of the per-group count memory; a byte that
// completes no word does not. A dictionary add of a repeated word holds off the next item.
// Clear, add and restart wait until earlier text bytes have left the pipeline.
// A result enters the 2-entry output queue from engine stage 2, after the stage-1
// and stage-2 registers, and can be presented once it is written there.
// When the receiver stalls, the output queue fills and req_tready drops for
// text bytes until space is reserved again; no result is lost.
// After reset word_length is 1, the dictionary is empty and the text restarts.

module word_multiset_window_matcher_core #(
   parameter int MAX_WORD_BYTES = 8,
   parameter int DICT_WORDS     = 16,
   parameter int POSITION_BITS  = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // [1:0] opcode, [65:2] word_value, [73:66] text_byte, [79:74] zero
   input  logic [wmm_pkg::TDATA_BITS-1:0]       req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [15:0] match_start
   output logic [wmm_pkg::START_BITS-1:0]       rsp_tdata,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [wmm_pkg::CSR_ADDR_BITS-1:0]    csr_paddr,
   input  logic [wmm_pkg::CSR_DATA_BITS-1:0]    csr_pwdata,
   output logic [wmm_pkg::CSR_DATA_BITS-1:0]    csr_prdata,
   output logic                                 csr_pready
);

   localparam int GRP_W   = (MAX_WORD_BYTES > 1) ? $clog2(MAX_WORD_BYTES) : 1;
   localparam int KW      = $clog2(MAX_WORD_BYTES + 1);
   localparam int ID_W    = $clog2(DICT_WORDS + 1);
   localparam int TALLY_W = $clog2(DICT_WORDS + 2);
   localparam int RB      = 8 * MAX_WORD_BYTES;
   localparam int SPAN_W  = ID_W + KW;

   wmm_pkg::opcode_type            op;
   logic [wmm_pkg::WORD_BITS-1:0]  in_word;
   logic [7:0]                     in_byte;
   logic                           acc, is_text, cfg_wr, cfg_hit, restart, clear;

   logic [wmm_pkg::LEN_BITS-1:0]   word_length_ff;
   logic [KW-1:0]                  k_eff;
   logic [RB-1:0]                  recent_ff, rec_in, rec_sh;
   logic [POSITION_BITS-1:0]       pos_ff, pos_in, start_full;
   logic [GRP_W-1:0]               group_ff, group_in;
   logic [KW-1:0]                  grp_inc;
   logic [KW-1:0]                  seen_ff, seen_in;
   logic [SPAN_W-1:0]              span;
   logic [wmm_pkg::WORD_BITS-1:0]  text_word, add_word, key;

   logic [ID_W-1:0]                lookup_id, distinct_after, total;
   logic                           dict_pend;
   logic [ID_W-1:0]                rq_a_id, rq_b_id, rq_a, rq_b;
   logic [TALLY_W-1:0]             restart_tally;
   logic                           step_valid;
   wmm_pkg::eng_status_type        status;
   wmm_pkg::eng_result_type        result;

   logic [wmm_pkg::START_BITS-1:0] fifo_ff [2];
   logic                           wr_ptr_ff, rd_ptr_ff;
   logic [1:0]                     cnt_ff;
   logic                           push, pop, room;

   assign op      = wmm_pkg::opcode_type'(req_tdata[1:0]);
   assign in_word = req_tdata[65:2];
   assign in_byte = req_tdata[73:66];
   assign is_text = (op == wmm_pkg::OP_TEXT);
   assign room    = (cnt_ff + {1'b0, status.s2}) < 2'd2;

   always_comb begin
      if (dict_pend || status.s1) begin
         req_tready = 1'b0;
      end else if (is_text) begin
         req_tready = room;
      end else begin
         req_tready = !(status.s2 || status.s3);
      end
   end

   assign acc = req_tvalid && req_tready;

   // configuration port
   assign cfg_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign cfg_hit    = (csr_paddr == wmm_pkg::ADDR_WORD_LENGTH);
   assign csr_pready = 1'b1;
   assign csr_prdata = cfg_hit ? wmm_pkg::CSR_DATA_BITS'(word_length_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         word_length_ff <= wmm_pkg::LEN_BITS'(1);
      end else if (cfg_wr && cfg_hit) begin
         word_length_ff <= csr_pwdata[wmm_pkg::LEN_BITS-1:0];
      end
   end

   always_comb begin
      if (word_length_ff == '0) begin
         k_eff = KW'(1);
      end else if (word_length_ff > wmm_pkg::LEN_BITS'(MAX_WORD_BYTES)) begin
         k_eff = KW'(MAX_WORD_BYTES);
      end else begin
         k_eff = KW'(word_length_ff);
      end
   end

   assign clear   = (acc && (op == wmm_pkg::OP_CLEAR)) || (cfg_wr && cfg_hit);
   assign restart = clear || (acc && !is_text);

   always_comb begin
      if (clear) begin
         restart_tally = '0;
      end else begin
         restart_tally = TALLY_W'(distinct_after);
      end
   end

   // text byte: shift in, extract the word that ends here
   always_comb begin
      rec_in  = RB'({in_byte, recent_ff} >> 8);
      rec_sh  = rec_in >> (8 * (MAX_WORD_BYTES - int'(k_eff)));
      text_word = '0;
      for (int j = 0; j < MAX_WORD_BYTES; j++) begin
         if (KW'(j) < k_eff) begin
            text_word[8*j +: 8] = rec_sh[8*j +: 8];
         end
      end
      add_word = '0;
      for (int j = 0; j < 8; j++) begin
         if (j < int'(k_eff)) begin
            add_word[8*j +: 8] = in_word[8*j +: 8];
         end
      end
      key = is_text ? text_word : add_word;

      seen_in  = (seen_ff < k_eff) ? seen_ff + 1'b1 : seen_ff;
      grp_inc  = KW'(group_ff) + 1'b1;
      group_in = (grp_inc >= k_eff) ? '0 : grp_inc[GRP_W-1:0];
      pos_in   = pos_ff + 1'b1;
      span     = SPAN_W'(total) * SPAN_W'(k_eff);
      start_full = pos_in - POSITION_BITS'(span);
   end

   assign step_valid = acc && is_text && (seen_in >= k_eff);

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         recent_ff <= '0;
         pos_ff    <= '0;
         group_ff  <= '0;
         seen_ff   <= '0;
      end else if (acc && is_text) begin
         recent_ff <= rec_in;
         pos_ff    <= pos_in;
         group_ff  <= group_in;
         seen_ff   <= seen_in;
      end
   end

   wmm_dict #(
      .DICT_WORDS (DICT_WORDS)
   ) u_dict (
      .clock          (clock),
      .reset          (reset),
      .clear          (clear),
      .add_valid      (acc && (op == wmm_pkg::OP_ADD)),
      .key            (key),
      .lookup_id      (lookup_id),
      .distinct_after (distinct_after),
      .total          (total),
      .pend           (dict_pend),
      .rd_a_id        (rq_a_id),
      .rd_b_id        (rq_b_id),
      .rd_a           (rq_a),
      .rd_b           (rq_b)
   );

   wmm_engine #(
      .MAX_WORD_BYTES (MAX_WORD_BYTES),
      .DICT_WORDS     (DICT_WORDS)
   ) u_engine (
      .clock         (clock),
      .reset         (reset),
      .restart       (restart),
      .restart_tally (restart_tally),
      .step_valid    (step_valid),
      .step_group    (group_in),
      .step_id       (lookup_id),
      .step_start    (wmm_pkg::START_BITS'(start_full)),
      .total         (total),
      .rq_a_id       (rq_a_id),
      .rq_b_id       (rq_b_id),
      .rq_a          (rq_a),
      .rq_b          (rq_b),
      .status        (status),
      .result        (result)
   );

   // output queue
   assign push       = result.valid;
   assign pop        = rsp_tvalid && rsp_tready;
   assign rsp_tvalid = (cnt_ff != 2'd0);
   assign rsp_tdata  = fifo_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ptr_ff] <= result.start;
      end
   end

endmodule

// File: verif/word_multiset_window_matcher_checker.sv
`timescale 1ns / 1ps

module word_multiset_window_matcher_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   input  logic                                req_tready,
   input  logic [wmm_pkg::TDATA_BITS-1:0]      req_tdata,
   input  logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic [wmm_pkg::START_BITS-1:0]      rsp_tdata,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [wmm_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  logic [wmm_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   output int                                  fail_count,
   output int                                  pending_starts
);
   import wmm_pkg::*;

   localparam int MAXB  = 8;
   localparam int NDICT = 16;
   localparam int NONE  = NDICT;
   localparam int SLOTS = NDICT + 1;

   logic [3:0]  len_reg;
   logic [63:0] dict [NDICT];
   int          need [NDICT];
   int          n_distinct, n_total;
   logic [63:0] shift_bytes;
   logic [15:0] pos;
   int          grp, seen;
   int          ids [MAXB*NDICT];
   int          head [MAXB];
   int          fill [MAXB];
   int          cnt [MAXB*SLOTS];
   int          tally [MAXB];
   logic [15:0] start_queue [$];

   function automatic int eff_len();
      if (len_reg == 0) return 1;
      if (len_reg > MAXB) return MAXB;
      return len_reg;
   endfunction

   function automatic logic [63:0] len_mask(int k);
      if (k >= 8) return '1;
      return (64'd1 << (8*k)) - 1;
   endfunction

   task automatic restart_text();
      shift_bytes = 0; pos = 0; grp = 0; seen = 0;
      foreach (ids[i]) ids[i] = 0;
      foreach (cnt[i]) cnt[i] = 0;
      for (int g = 0; g < MAXB; g++) begin
         head[g] = 0; fill[g] = 0; tally[g] = n_distinct;
      end
   endtask

   task automatic clear_all();
      foreach (dict[i]) begin
         dict[i] = 0; need[i] = 0;
      end
      n_distinct = 0; n_total = 0;
      restart_text();
   endtask

   function automatic int find_word(logic [63:0] w);
      for (int i = 0; i < n_distinct; i++)
         if (dict[i] == w) return i;
      return NONE;
   endfunction

   task automatic bump(int g, int id, bit up);
      int r;
      r = (id < NDICT) ? need[id] : 0;
      if (cnt[g*SLOTS+id] == r) tally[g]++;
      if (up) cnt[g*SLOTS+id]++;
      else if (cnt[g*SLOTS+id] > 0) cnt[g*SLOTS+id]--;
      if (cnt[g*SLOTS+id] == r && tally[g] > 0) tally[g]--;
   endtask

   task automatic step_matcher(logic [TDATA_BITS-1:0] d);
      opcode_type op;
      int k, g, id, m, slot;
      logic [63:0] w;
      op = opcode_type'(d[1:0]);
      k = eff_len();
      case (op)
         OP_CLEAR: clear_all();
         OP_RESTART: restart_text();
         OP_ADD: begin
            w = d[65:2] & len_mask(k);
            if (n_total < NDICT) begin
               id = find_word(w);
               if (id == NONE) begin
                  dict[n_distinct] = w; need[n_distinct] = 1;
                  n_distinct++; n_total++;
               end else begin
                  need[id]++; n_total++;
               end
            end
            restart_text();
         end
         OP_TEXT: begin
            g = (grp + 1) % k;
            shift_bytes = {d[73:66], shift_bytes[63:8]};
            if (seen < k) seen++;
            if (seen >= k) begin
               w = (shift_bytes >> (8*(8-k))) & len_mask(k);
               id = find_word(w);
               m = n_total;
               if (fill[g] >= m && fill[g] > 0) begin
                  bump(g, ids[g*NDICT+head[g]], 0);
                  head[g] = (head[g] + 1) % NDICT;
                  fill[g]--;
               end
               if (m > 0 && fill[g] < NDICT) begin
                  slot = (head[g] + fill[g]) % NDICT;
                  ids[g*NDICT+slot] = id;
                  fill[g]++;
                  bump(g, id, 1);
               end
               if (m > 0 && fill[g] == m && tally[g] == 0)
                  start_queue = {start_queue, 16'(pos + 1 - m*k)};
            end
            pos++;
            grp = (grp + 1) % k;
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      if (reset) begin
         len_reg = 4'd1;
         clear_all();
         start_queue = {};
         fail_count = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_paddr == ADDR_WORD_LENGTH) begin
            len_reg = csr_pwdata[3:0];
            clear_all();
         end
         // check before predicting: a result never shares a cycle with its byte
         if (rsp_tvalid && rsp_tready) begin
            if (start_queue.size() == 0) begin
               $error("unexpected match_start %0d", rsp_tdata);
               fail_count++;
            end else begin
               if (rsp_tdata !== start_queue[0]) begin
                  $error("match_start expected %0d actual %0d", start_queue[0], rsp_tdata);
                  fail_count++;
               end
               void'(start_queue.pop_front());
            end
         end
         if (req_tvalid && req_tready) step_matcher(req_tdata);
      end
      pending_starts = start_queue.size();
   end
endmodule

// File: verif/word_multiset_window_matcher_core_tb.sv
`timescale 1ns / 1ps

module word_multiset_window_matcher_core_tb;
   import wmm_pkg::*;

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0, req_tready;
   logic [TDATA_BITS-1:0] req_tdata = '0;
   logic rsp_tvalid, rsp_tready = 0;
   logic [START_BITS-1:0] rsp_tdata;
   logic csr_psel = 0, csr_penable = 0, csr_pwrite = 0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr = '0;
   logic [CSR_DATA_BITS-1:0] csr_pwdata = '0, csr_prdata;
   logic csr_pready;
   int   fail_count, pending_starts;
   int   cycle_count = 0;
   int   gap_left = 0;
   logic [63:0] vocab [4];

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   word_multiset_window_matcher_core dut (.*);

   word_multiset_window_matcher_checker checker_i (.*);

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > 400000) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // receiver stall pattern: long open runs alternate with random stalls
   always @(negedge clock) begin
      if (cycle_count % 600 < 200) rsp_tready <= 1;
      else rsp_tready <= ($urandom_range(0, 2) != 0);
   end

   // hold tvalid after the transaction; a gap in the next call or drain() drops it
   task automatic send_item(opcode_type op, logic [63:0] w, logic [7:0] b);
      if (gap_left > 0) begin
         gap_left--;
         req_tvalid <= 0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end else if ($urandom_range(0, 15) == 0) begin
         gap_left = $urandom_range(0, 3);
      end
      req_tvalid <= 1;
      req_tdata <= {6'd0, b, w, op};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 0;
      while (pending_starts != 0) @(negedge clock);
      repeat (10) @(negedge clock);
   endtask

   task automatic write_len(logic [3:0] v);
      drain();
      csr_psel <= 1; csr_pwrite <= 1; csr_paddr <= ADDR_WORD_LENGTH;
      csr_pwdata <= {$urandom} & 32'hFFFF_FFF0 | v;
      @(negedge clock);
      csr_penable <= 1;
      @(negedge clock);
      csr_psel <= 0; csr_penable <= 0; csr_pwrite <= 0;
   endtask

   function automatic logic [7:0] byte_of(logic [63:0] w, int i);
      return w[8*i +: 8];
   endfunction

   task automatic run_phase(int k, int items);
      int n, sel;
      logic [63:0] w;
      for (int i = 0; i < 4; i++) vocab[i] = {$urandom, $urandom} & 64'h0303_0303_0303_0303;
      send_item(OP_CLEAR, '0, '0);
      n = $urandom_range(1, 4);
      for (int i = 0; i < n; i++) send_item(OP_ADD, vocab[$urandom_range(0, 2)], 8'($urandom));
      while (items > 0) begin
         sel = $urandom_range(0, 99);
         if (sel < 85) begin
            w = vocab[$urandom_range(0, 3)];
            for (int j = 0; j < k; j++) send_item(OP_TEXT, {$urandom, $urandom},
               ($urandom_range(0, 19) == 0) ? 8'($urandom) : byte_of(w, j));
            items -= k;
         end else if (sel < 90) begin
            send_item(OP_TEXT, {$urandom, $urandom}, 8'($urandom)); items--;
         end else if (sel < 94) begin
            send_item(OP_RESTART, {$urandom, $urandom}, 8'($urandom)); items--;
         end else if (sel < 97) begin
            send_item(OP_ADD, vocab[$urandom_range(0, 3)] ^ {$urandom, $urandom},
               8'($urandom));
            items--;
         end else begin
            send_item(OP_CLEAR, {$urandom, $urandom}, 8'($urandom));
            send_item(OP_ADD, vocab[0], 8'h00);
            items -= 2;
         end
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      // directed: extremes, duplicates, full dictionary, wrap-free basics
      send_item(OP_TEXT, '0, 8'hFF);
      send_item(OP_ADD, '1, 8'h00);
      send_item(OP_ADD, '1, 8'hFF);
      send_item(OP_TEXT, '0, 8'hFF);
      send_item(OP_TEXT, '1, 8'hFF);
      send_item(OP_TEXT, '0, 8'h00);
      send_item(OP_RESTART, '1, 8'hFF);
      send_item(OP_TEXT, '0, 8'hFF);
      send_item(OP_TEXT, '0, 8'hFF);
      for (int i = 0; i < 17; i++) send_item(OP_ADD, 64'(i % 3), 8'h00);
      send_item(OP_TEXT, '0, 8'h00);
      send_item(OP_CLEAR, '1, 8'hFF);
      send_item(OP_TEXT, '0, 8'h00);
      write_len(4'd0);
      run_phase(1, 150);
      write_len(4'd8);
      send_item(OP_ADD, 64'hFFEE_DDCC_BBAA_9988, 8'h00);
      for (int j = 0; j < 8; j++) send_item(OP_TEXT, '0, byte_of(64'hFFEE_DDCC_BBAA_9988, j));
      run_phase(8, 150);
      write_len(4'd15);
      run_phase(8, 80);
      write_len(4'd2);
      run_phase(2, 200);
      write_len(4'd3);
      run_phase(3, 200);
      write_len(4'd1);
      run_phase(1, 100);
      drain();
      if (fail_count == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end
endmodule
